// ===== rtl/core/rpdc_pkg.sv =====
package rpdc_pkg;

	localparam int unsigned TIME_W    = 16;
	localparam int unsigned DEMAND_W  = 17;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(FRAC_BITS);

	localparam logic [TIME_W-1:0] LONGEST_RESET  = 16'd31500;
	localparam logic [TIME_W-1:0] SHORTEST_RESET = 16'd22500;
	localparam logic [TIME_W-1:0] THRESH_RESET   = 16'd9000;
	localparam logic [DEMAND_W-1:0] FULL_SCALE   = 17'h10000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic update;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic glitch;
		logic div_last;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/core/rpdc_datapath.sv =====
module rpdc_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rpdc_pkg::ctrl_cmd_t                     cmd,
	output rpdc_pkg::dp_status_t                    status,
	input  logic [rpdc_pkg::TIME_W-1:0]             rise_time,
	input  logic [rpdc_pkg::TIME_W-1:0]             fall_time,
	input  logic                                    cfg_valid,
	input  logic [rpdc_pkg::TIME_W-1:0]             cfg_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [rpdc_pkg::DEMAND_W-1:0]           demand,
	output logic [rpdc_pkg::TIME_W-1:0]             longest_seen,
	output logic [rpdc_pkg::TIME_W-1:0]             shortest_seen
);
	import rpdc_pkg::*;

	logic [TIME_W-1:0]    thresh_q;
	logic [TIME_W-1:0]    width_q;
	logic [TIME_W-1:0]    longest_q;
	logic [TIME_W-1:0]    shortest_q;
	logic [TIME_W-1:0]    range_q;
	logic [TIME_W-1:0]    rem_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic                 sat_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic              grow_long;
	logic              grow_short;
	logic [TIME_W-1:0] new_long;
	logic [TIME_W-1:0] new_short;
	logic [TIME_W-1:0] new_range;
	logic [TIME_W-1:0] new_pulse;
	logic [TIME_W:0]   rem_sh;
	logic [TIME_W:0]   rem_diff;
	logic              q_bit;

	assign grow_long  = width_q > longest_q;
	assign grow_short = !grow_long && (width_q < shortest_q);
	assign new_long   = grow_long ? width_q : longest_q;
	assign new_short  = grow_short ? width_q : shortest_q;
	assign new_range  = new_long - new_short;
	assign new_pulse  = width_q - new_short;

	// One restoring division step; the remainder stays below the range.
	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, range_q};
	assign q_bit    = !rem_diff[TIME_W];

	assign status.glitch   = width_q <= thresh_q;
	assign status.div_last = cnt_q == {DIV_CNT_W{1'b1}};
	assign status.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= THRESH_RESET;
			longest_q  <= LONGEST_RESET;
			shortest_q <= SHORTEST_RESET;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thresh_q <= cfg_data;
			end
			if (cmd.update) begin
				longest_q  <= new_long;
				shortest_q <= new_short;
				cnt_q      <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			width_q <= fall_time - rise_time;
		end
		if (cmd.update) begin
			range_q <= new_range;
			rem_q   <= new_pulse;
			sat_q   <= (new_range == '0) || (new_pulse >= new_range);
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], q_bit};
		end
		if (cmd.out_load) begin
			demand        <= sat_q ? FULL_SCALE : {1'b0, quot_q};
			longest_seen  <= longest_q;
			shortest_seen <= shortest_q;
		end
	end

endmodule

// ===== rtl/core/rpdc_controller.sv =====
module rpdc_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpdc_pkg::dp_status_t status,
	output rpdc_pkg::ctrl_cmd_t  cmd
);
	import rpdc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.glitch) begin
					state_d = ST_IDLE;
				end else begin
					cmd.update = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold the finished result until the output register is free.
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/rc_pulse_demand_calibrator.sv =====
// Channel   Direction  Beat contents
// s_*       in         tdata[15:0] rise_time, tdata[31:16] fall_time
// m_*       out        tdata[16:0] demand, [32:17] longest_seen, [48:33] shortest_seen
// cfg_*     in         cfg_data[15:0] glitch_threshold
//
// A pulse goes from input beat to output register through capture, a check and
// update of the extremes, the bit-serial divider and the load, which waits on a stalled output.
// A glitch pulse produces no output beat.
// Reset restores the threshold and both extremes; no clearing pass is needed.
// A stalled output beat holds in its register; a new input beat is still taken.
module rc_pulse_demand_calibrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // rise_time, fall_time
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // demand, longest_seen, shortest_seen, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // glitch_threshold
);
	import rpdc_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        status;
	logic [DEMAND_W-1:0] demand;
	logic [TIME_W-1:0]   longest_seen;
	logic [TIME_W-1:0]   shortest_seen;

	assign cfg_ready = 1'b1;

	rpdc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rpdc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.rise_time     (s_tdata[15:0]),
		.fall_time     (s_tdata[31:16]),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.demand        (demand),
		.longest_seen  (longest_seen),
		.shortest_seen (shortest_seen)
	);

	assign m_tdata = {7'd0, shortest_seen, longest_seen, demand};

endmodule
